/* rtl/scc_pkg.sv */
package scc_pkg;

   localparam int SLOTS  = 64;
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int TAG_W  = 32;
   localparam int SLOT_W = 6;

   typedef enum logic [1:0] {
      OP_ACCESS  = 2'd0,
      OP_RELEASE = 2'd1,
      OP_FLUSH   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_HIT     = 3'd0,
      KIND_FILL    = 3'd1,
      KIND_NOVIC   = 3'd2,
      KIND_FLUSHED = 3'd3,
      KIND_RELEASE = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_HIT_OUT,
      ST_MISS,
      ST_FILL_OUT,
      ST_REL_OUT,
      ST_FL_PICK,
      ST_FL_OUT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic search;
      logic advance;
      logic hit_out;
      logic miss_pick;
      logic fill_out;
      logic rel_out;
      logic fl_pick;
      logic fl_out;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   found;
      logic   match;
      logic   any_valid;
      logic   out_free;
   } status_type;

   function automatic logic [IDX_W-1:0] first_one(input logic [SLOTS-1:0] vec);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (vec[i]) r = IDX_W'(i);
      end
      return r;
   endfunction

   function automatic logic [SLOTS-1:0] below_mask(input logic [CNT_W-1:0] n);
      logic [SLOTS-1:0] m;
      for (int i = 0; i < SLOTS; i++) begin
         m[i] = (i < int'(n));
      end
      return m;
   endfunction

endpackage

/* rtl/scc_ctrl.sv */
module scc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  scc_pkg::status_type   status,
   output scc_pkg::cmd_type      cmd
);

   scc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               case (status.op)
                  scc_pkg::OP_ACCESS:  state_in = scc_pkg::ST_SEARCH;
                  scc_pkg::OP_RELEASE: state_in = scc_pkg::ST_REL_OUT;
                  scc_pkg::OP_FLUSH:   state_in = scc_pkg::ST_FL_PICK;
                  default:             state_in = scc_pkg::ST_IDLE;
               endcase
            end
         end
         scc_pkg::ST_SEARCH: begin
            state_in = status.found ? scc_pkg::ST_COMPARE : scc_pkg::ST_MISS;
         end
         scc_pkg::ST_COMPARE: begin
            state_in = status.match ? scc_pkg::ST_HIT_OUT : scc_pkg::ST_SEARCH;
         end
         scc_pkg::ST_HIT_OUT: begin
            if (status.out_free) state_in = scc_pkg::ST_IDLE;
         end
         scc_pkg::ST_MISS: begin
            state_in = scc_pkg::ST_FILL_OUT;
         end
         scc_pkg::ST_FILL_OUT: begin
            if (status.out_free) state_in = scc_pkg::ST_IDLE;
         end
         scc_pkg::ST_REL_OUT: begin
            if (status.out_free) state_in = scc_pkg::ST_IDLE;
         end
         scc_pkg::ST_FL_PICK: begin
            state_in = status.any_valid ? scc_pkg::ST_FL_OUT : scc_pkg::ST_IDLE;
         end
         scc_pkg::ST_FL_OUT: begin
            if (status.out_free) state_in = scc_pkg::ST_FL_PICK;
         end
         default: begin
            state_in = scc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         scc_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         scc_pkg::ST_SEARCH:   cmd.search    = 1'b1;
         scc_pkg::ST_COMPARE:  cmd.advance   = !status.match;
         scc_pkg::ST_HIT_OUT:  cmd.hit_out   = status.out_free;
         scc_pkg::ST_MISS:     cmd.miss_pick = 1'b1;
         scc_pkg::ST_FILL_OUT: cmd.fill_out  = status.out_free;
         scc_pkg::ST_REL_OUT:  cmd.rel_out   = status.out_free;
         scc_pkg::ST_FL_PICK:  cmd.fl_pick   = status.any_valid;
         scc_pkg::ST_FL_OUT:   cmd.fl_out    = status.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/scc_dp.sv */
module scc_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  req_opcode,
   input  logic [scc_pkg::TAG_W-1:0]   req_sector,
   input  logic                        req_write_flag,
   input  logic [scc_pkg::SLOT_W-1:0]  req_slot_in,
   input  scc_pkg::cmd_type            cmd,
   output scc_pkg::status_type         status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_kind,
   output logic [scc_pkg::SLOT_W-1:0]  rsp_slot,
   output logic [scc_pkg::TAG_W-1:0]   rsp_victim_sector,
   output logic                        rsp_write_back,
   output logic                        rsp_last
);

   localparam int S = scc_pkg::SLOTS;
   localparam int IW = scc_pkg::IDX_W;

   logic [scc_pkg::TAG_W-1:0]  tag_mem [S];
   logic [scc_pkg::TAG_W-1:0]  rd_ff;

   logic [S-1:0] valid_ff, valid_in, dirty_ff, dirty_in;
   logic [S-1:0] pinned_ff, pinned_in, ref_ff, ref_in;

   logic [1:0]                 op_ff;
   logic [scc_pkg::TAG_W-1:0]  sector_ff;
   logic                       wr_ff;
   logic [scc_pkg::SLOT_W-1:0] slot_in_ff;
   logic [scc_pkg::CNT_W-1:0]  start_ff, start_in;
   logic [IW-1:0]              idx_ff;
   logic                       fail_ff;

   logic                       rsp_valid_ff;
   logic [2:0]                 kind_ff;
   logic [scc_pkg::SLOT_W-1:0] slot_ff;
   logic [scc_pkg::TAG_W-1:0]  vsec_ff;
   logic                       wb_ff, last_ff;

   logic [S-1:0]  srch_vec, unp, cand, ref_vic, fl_rest;
   logic [IW-1:0] srch_idx, vic_idx, fl_idx, rd_addr;
   logic          vic_fail, out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign srch_vec = valid_ff & ~scc_pkg::below_mask(start_ff);
   assign srch_idx = scc_pkg::first_one(srch_vec);
   assign fl_idx   = scc_pkg::first_one(valid_ff);
   assign fl_rest  = valid_ff & ~(S'(1) << fl_idx);
   assign unp      = ~pinned_ff;
   assign cand     = unp & ~ref_ff;

   // second chance victim choice
   always_comb begin
      vic_idx  = '0;
      vic_fail = 1'b0;
      ref_vic  = ref_ff;
      if (|(~valid_ff)) begin
         vic_idx = scc_pkg::first_one(~valid_ff);
      end else if (|cand) begin
         vic_idx = scc_pkg::first_one(cand);
         ref_vic = ref_ff & ~(unp & scc_pkg::below_mask(scc_pkg::CNT_W'(vic_idx)));
      end else if (|unp) begin
         vic_idx = scc_pkg::first_one(unp);
         ref_vic = ref_ff & ~unp;
      end else begin
         vic_fail = 1'b1;
      end
   end

   always_comb begin
      if (cmd.search) begin
         rd_addr = srch_idx;
      end else if (cmd.miss_pick) begin
         rd_addr = vic_idx;
      end else begin
         rd_addr = fl_idx;
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      dirty_in  = dirty_ff;
      pinned_in = pinned_ff;
      ref_in    = ref_ff;
      start_in  = start_ff;
      if (cmd.load_req) start_in = '0;
      if (cmd.advance) start_in = scc_pkg::CNT_W'(idx_ff) + 1'b1;
      if (cmd.miss_pick) ref_in = ref_vic;
      if (cmd.hit_out) pinned_in[idx_ff] = 1'b1;
      if (cmd.fill_out && !fail_ff) begin
         valid_in[idx_ff]  = 1'b1;
         dirty_in[idx_ff]  = wr_ff;
         pinned_in[idx_ff] = 1'b1;
         ref_in[idx_ff]    = 1'b1;
      end
      if (cmd.rel_out && (int'(slot_in_ff) < S)) pinned_in[IW'(slot_in_ff)] = 1'b0;
      if (cmd.fl_out) begin
         valid_in[idx_ff] = 1'b0;
         dirty_in[idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         dirty_ff     <= '0;
         pinned_ff    <= '0;
         ref_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         dirty_ff  <= dirty_in;
         pinned_ff <= pinned_in;
         ref_ff    <= ref_in;
         if (cmd.hit_out || cmd.fill_out || cmd.rel_out || cmd.fl_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      if (cmd.load_req) begin
         op_ff      <= req_opcode;
         sector_ff  <= req_sector;
         wr_ff      <= req_write_flag;
         slot_in_ff <= req_slot_in;
      end
      if (cmd.search || cmd.miss_pick || cmd.fl_pick) begin
         rd_ff  <= tag_mem[rd_addr];
         idx_ff <= rd_addr;
      end
      if (cmd.miss_pick) fail_ff <= vic_fail;
      if (cmd.fill_out && !fail_ff) tag_mem[idx_ff] <= sector_ff;
      if (cmd.hit_out) begin
         kind_ff <= scc_pkg::KIND_HIT;
         slot_ff <= scc_pkg::SLOT_W'(idx_ff);
         vsec_ff <= '0;
         wb_ff   <= 1'b0;
         last_ff <= 1'b1;
      end
      if (cmd.fill_out) begin
         kind_ff <= fail_ff ? scc_pkg::KIND_NOVIC : scc_pkg::KIND_FILL;
         slot_ff <= fail_ff ? '0 : scc_pkg::SLOT_W'(idx_ff);
         vsec_ff <= (!fail_ff && valid_ff[idx_ff]) ? rd_ff : '0;
         wb_ff   <= !fail_ff && valid_ff[idx_ff] && dirty_ff[idx_ff];
         last_ff <= 1'b1;
      end
      if (cmd.rel_out) begin
         kind_ff <= scc_pkg::KIND_RELEASE;
         slot_ff <= slot_in_ff;
         vsec_ff <= '0;
         wb_ff   <= 1'b0;
         last_ff <= 1'b1;
      end
      if (cmd.fl_out) begin
         kind_ff <= scc_pkg::KIND_FLUSHED;
         slot_ff <= scc_pkg::SLOT_W'(idx_ff);
         vsec_ff <= rd_ff;
         wb_ff   <= dirty_ff[idx_ff];
         last_ff <= !(|(valid_ff & ~(S'(1) << idx_ff)));
      end
   end

   assign status.op        = scc_pkg::op_type'(cmd.load_req ? req_opcode : op_ff);
   assign status.found     = |srch_vec;
   assign status.match     = (rd_ff == sector_ff);
   assign status.any_valid = |valid_ff && (fl_rest != valid_ff);
   assign status.out_free  = out_free;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_slot          = slot_ff;
   assign rsp_victim_sector = vsec_ff;
   assign rsp_write_back    = wb_ff;
   assign rsp_last          = last_ff;

endmodule

/* rtl/sector_cache_second_chance.sv */
// access compares valid slots in turn up to the hit, or all of them, then picks a victim on a miss
// release gives one result, flush one per valid slot; each result waits for rsp_tready
// throughput: one request at a time, limited by the single-port tag memory scan
// reset: synchronous, active high; clears valid, dirty, pinned and referenced bits
// and the result valid flag; tag memory is not cleared and its contents are used only for valid slots
module sector_cache_second_chance (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // sector, write_flag, slot_in, zero pad
   input  logic [1:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // slot, victim_sector, write_back, zero pad
   output logic [2:0]  rsp_tuser,   // kind
   output logic        rsp_tlast
);

   scc_pkg::cmd_type    cmd;
   scc_pkg::status_type status;
   logic [scc_pkg::SLOT_W-1:0] slot;
   logic [scc_pkg::TAG_W-1:0]  vsec;
   logic                       wb;

   scc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   scc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_tuser),
      .req_sector        (req_tdata[31:0]),
      .req_write_flag    (req_tdata[32]),
      .req_slot_in       (req_tdata[38:33]),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_kind          (rsp_tuser),
      .rsp_slot          (slot),
      .rsp_victim_sector (vsec),
      .rsp_write_back    (wb),
      .rsp_last          (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, wb, vsec, slot};

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

typedef struct {
   scc_pkg::kind_type kind;
   logic [5:0]        slot;
   logic [31:0]       victim;
   logic              wb;
   logic              last;
} cache_rsp_type;

class cache_scoreboard;
   logic [31:0]   tags [scc_pkg::SLOTS];
   bit            vld [scc_pkg::SLOTS];
   bit            drt [scc_pkg::SLOTS];
   bit            pin [scc_pkg::SLOTS];
   bit            refd [scc_pkg::SLOTS];
   cache_rsp_type pending [$];
   int            errors;
   int            checked;

   function new();
      for (int i = 0; i < scc_pkg::SLOTS; i++) begin
         tags[i] = '0;
         vld[i] = 1'b0;
         drt[i] = 1'b0;
         pin[i] = 1'b0;
         refd[i] = 1'b0;
      end
      errors = 0;
      checked = 0;
   endfunction

   task report(string msg);
      $display("%s", msg);
      errors++;
   endtask

   function void push(scc_pkg::kind_type k, int s, logic [31:0] v, bit w, bit l);
      cache_rsp_type r;
      r.kind = k;
      r.slot = 6'(s);
      r.victim = v;
      r.wb = w;
      r.last = l;
      pending.push_back(r);
   endfunction

   function int choose_victim();
      for (int i = 0; i < scc_pkg::SLOTS; i++)
         if (!vld[i]) return i;
      for (int p = 0; p < 2; p++) begin
         for (int i = 0; i < scc_pkg::SLOTS; i++) begin
            if (pin[i]) continue;
            if (refd[i]) begin
               refd[i] = 1'b0;
               continue;
            end
            return i;
         end
      end
      return -1;
   endfunction

   function void note_request(scc_pkg::op_type op, logic [31:0] sec, bit wr,
                              logic [5:0] sin);
      int v;
      int n;
      if (op == scc_pkg::OP_ACCESS) begin
         for (int i = 0; i < scc_pkg::SLOTS; i++) begin
            if (vld[i] && tags[i] == sec) begin
               pin[i] = 1'b1;
               push(scc_pkg::KIND_HIT, i, '0, 1'b0, 1'b1);
               return;
            end
         end
         v = choose_victim();
         if (v < 0) begin
            push(scc_pkg::KIND_NOVIC, 0, '0, 1'b0, 1'b1);
            return;
         end
         push(scc_pkg::KIND_FILL, v, vld[v] ? tags[v] : 32'd0,
              vld[v] ? drt[v] : 1'b0, 1'b1);
         tags[v] = sec;
         vld[v] = 1'b1;
         drt[v] = wr;
         refd[v] = 1'b1;
         pin[v] = 1'b1;
      end else if (op == scc_pkg::OP_RELEASE) begin
         if (int'(sin) < scc_pkg::SLOTS) pin[sin] = 1'b0;
         push(scc_pkg::KIND_RELEASE, int'(sin), '0, 1'b0, 1'b1);
      end else if (op == scc_pkg::OP_FLUSH) begin
         n = 0;
         for (int i = 0; i < scc_pkg::SLOTS; i++) begin
            if (!vld[i]) continue;
            push(scc_pkg::KIND_FLUSHED, i, tags[i], drt[i], 1'b0);
            vld[i] = 1'b0;
            drt[i] = 1'b0;
            n++;
         end
         if (n > 0) pending[pending.size() - 1].last = 1'b1;
      end
   endfunction

   task check_result(scc_pkg::kind_type k, logic [5:0] s, logic [31:0] v, bit w, bit l);
      cache_rsp_type e;
      checked++;
      if (pending.size() == 0) begin
         report($sformatf("unexpected beat kind %0d slot %0d", k, s));
         return;
      end
      e = pending.pop_front();
      if (k !== e.kind || s !== e.slot || v !== e.victim || w !== e.wb || l !== e.last) begin
         report($sformatf("mismatch: got k%0d s%0d v%h wb%0b l%0b exp k%0d s%0d v%h wb%0b l%0b",
                          k, s, v, w, l, e.kind, e.slot, e.victim, e.wb, e.last));
      end
   endtask
endclass

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   cache_scoreboard sb = new();
   bit   calm = 0;
   int   cycles = 0;
   int   sent = 0;
   int   stall_left = 0;
   logic [31:0] hot [8];

   sector_cache_second_chance uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("timeout");
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(scc_pkg::kind_type'(rsp_tuser), rsp_tdata[5:0], rsp_tdata[37:6],
                         rsp_tdata[38], rsp_tlast);
      if (reset) begin
         rsp_tready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 9) - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   task automatic send(scc_pkg::op_type op, logic [31:0] sec, bit wr, logic [5:0] sin);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {1'b0, sin, wr, sec};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, sec, wr, sin);
      sent++;
   endtask

   task automatic rand_item();
      int r;
      logic [31:0] sec;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         sec = ($urandom_range(0, 2) == 0) ? $urandom() : hot[$urandom_range(0, 7)];
         send(scc_pkg::OP_ACCESS, sec, 1'($urandom_range(0, 1)), 6'($urandom()));
      end else if (r < 92) begin
         send(scc_pkg::OP_RELEASE, $urandom(), 1'($urandom_range(0, 1)), 6'($urandom()));
      end else if (r < 97) begin
         send(scc_pkg::OP_FLUSH, $urandom(), 1'($urandom_range(0, 1)), 6'($urandom()));
      end else begin
         send(scc_pkg::OP_NONE, $urandom(), 1'($urandom_range(0, 1)), 6'($urandom()));
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) hot[i] = $urandom();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(scc_pkg::OP_FLUSH, '0, 1'b0, '0);
      send(scc_pkg::OP_ACCESS, 32'h0, 1'b0, 6'h3f);
      send(scc_pkg::OP_ACCESS, 32'hffffffff, 1'b1, 6'h00);
      send(scc_pkg::OP_ACCESS, 32'hffffffff, 1'b0, 6'h00);
      send(scc_pkg::OP_RELEASE, '0, 1'b0, 6'd63);
      send(scc_pkg::OP_RELEASE, '0, 1'b0, 6'd1);
      send(scc_pkg::OP_RELEASE, '0, 1'b0, 6'd40);
      send(scc_pkg::OP_NONE, 32'hffffffff, 1'b1, 6'h3f);
      for (int i = 0; i < 64; i++)
         send(scc_pkg::OP_ACCESS, 32'h1000 + 32'(i), i[0], 6'(i));
      send(scc_pkg::OP_ACCESS, 32'h5555aaaa, 1'b1, '0);
      for (int i = 0; i < 64; i += 3) send(scc_pkg::OP_RELEASE, '0, 1'b0, 6'(i));
      send(scc_pkg::OP_ACCESS, 32'haaaa5555, 1'b0, '0);
      send(scc_pkg::OP_ACCESS, 32'h12345678, 1'b1, '0);
      send(scc_pkg::OP_FLUSH, '0, 1'b0, '0);
      send(scc_pkg::OP_FLUSH, '0, 1'b0, '0);
      for (int n = 0; n < 330; n++) begin
         if (n > 280) calm = 1;
         rand_item();
      end
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d requests, checked %0d result beats", sent, sb.checked);
      $display("covered hits, fills with write-back, full-cache misses, releases and flushes");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

/* files.f */
rtl/scc_pkg.sv
rtl/scc_ctrl.sv
rtl/scc_dp.sv
rtl/sector_cache_second_chance.sv
verif/tb.sv
